>>> sv/jdc_pkg.sv
// Shared constants, result types and calendar tables of the Julian day converter.
package jdc_pkg;

  localparam int LAT             = 6;
  localparam int Y_OFS           = 4800;
  localparam int JD_OFS_FWD      = 32045;
  localparam int JD_OFS_REV      = 32044;
  localparam int SECS_PER_DAY    = 86400;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_MIN    = 60;
  localparam int DAYS_PER_YEAR   = 365;
  localparam int DAYS_400Y       = 146097;
  localparam int DAYS_4Y         = 1461;
  localparam int MONTHS_PER_YEAR = 12;

  localparam logic CMD_TO_DAY  = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_t;

  typedef struct packed {
    logic [22:0] day_number;
    logic [16:0] seconds_of_day;
    logic [2:0]  weekday;
    logic        date_valid;
  } fwd_res_t;

  typedef struct packed {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } rev_res_t;

  // days from March 1st to the start of shifted month m
  function automatic logic [8:0] mon_ofs(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      4'd12:   v = 9'd367;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] mon_len(input logic [3:0] mo, input logic leap);
    logic [4:0] v;
    case (mo) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     v = 5'd30;
      4'd2:                                        v = leap ? 5'd29 : 5'd28;
      default:                                     v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/jdc_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
module jdc_cdiv #(
  parameter int NW = 8,
  parameter int D  = 3,
  parameter int QW = 8,
  parameter int RW = 2
) (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  output logic [QW-1:0] quo_o,
  output logic [RW-1:0] rem_o
);

  localparam longint unsigned K = (64'd1 << NW) / D;
  localparam int KW = $clog2(K + 1);
  localparam int PW = NW + KW;
  localparam logic [NW-1:0] DN = NW'(D);
  localparam logic [KW-1:0] KC = KW'(K);

  logic [NW-1:0] num_r;
  logic [PW-1:0] prod_nxt, prod_r;
  logic [NW-1:0] q0, qd, r0, q1, r1;
  logic          fix;
  logic [QW-1:0] quo_nxt, quo_r;
  logic [RW-1:0] rem_nxt, rem_r;

  assign prod_nxt = PW'(num_i) * PW'(KC);

  always_comb begin
    q0      = NW'(prod_r[PW-1:NW]);
    qd      = q0 * DN;
    r0      = num_r - qd;
    fix     = (r0 >= DN);
    q1      = q0 + NW'(fix);
    r1      = fix ? r0 - DN : r0;
    quo_nxt = QW'(q1);
    rem_nxt = RW'(r1);
  end

  always_ff @(posedge clk) begin
    num_r  <= num_i;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

  assign quo_o = quo_r;
  assign rem_o = rem_r;

endmodule

>>> sv/jdc_fwd.sv
// Civil date and time to day number, seconds of day, weekday and validity, six stages.
module jdc_fwd (
  input  logic              clk,
  input  jdc_pkg::civil_t   civ_i,
  output jdc_pkg::fwd_res_t res_o
);

  // stage 1
  logic        a1_c;
  logic [3:0]  msh1_c;
  logic [14:0] y1_nxt, y1_r;
  logic [8:0]  off1_nxt, off1_r;
  logic [16:0] secs1_nxt, secs1_r;
  logic        fok1_nxt, fok1_r;
  logic [13:0] year1_r;
  logic [3:0]  month1_r;
  logic [4:0]  day1_r;

  // stage 2 and 3
  logic        carry2_c;
  logic [22:0] base2_nxt, base2_r, base3_r;
  logic [16:0] secn2_nxt, secn2_r, secn3_r;
  logic [3:0]  month2_r, month3_r;
  logic [4:0]  day2_r, day3_r;
  logic        fok2_r, fok3_r;
  logic [3:0]  ylo2_r, ylo3_r;
  logic [7:0]  q100;
  logic [4:0]  yr25;

  // stage 4 to 6
  logic        leap4_c;
  logic [22:0] jdn4_nxt, jdn4_r, jdn5_r, jdn6_r;
  logic        valid4_nxt, valid4_r, valid5_r, valid6_r;
  logic [16:0] secn4_r, secn5_r, secn6_r;
  logic [2:0]  wd6;

  always_comb begin
    a1_c      = (civ_i.month <= 4'd2);
    msh1_c    = a1_c ? civ_i.month + 4'd9 : civ_i.month - 4'd3;
    y1_nxt    = 15'(civ_i.year) + 15'(jdc_pkg::Y_OFS) - 15'(a1_c);
    off1_nxt  = jdc_pkg::mon_ofs(msh1_c);
    secs1_nxt = 17'(civ_i.hour) * 17'(jdc_pkg::SECS_PER_HOUR)
              + 17'(civ_i.minute) * 17'(jdc_pkg::SECS_PER_MIN)
              + 17'(civ_i.second);
    fok1_nxt  = (civ_i.month != 4'd0) && (civ_i.month <= 4'(jdc_pkg::MONTHS_PER_YEAR))
             && (civ_i.day != 5'd0) && (civ_i.hour <= 5'd23)
             && (civ_i.minute <= 6'd59) && (civ_i.second <= 6'd59);
  end

  always_ff @(posedge clk) begin
    y1_r     <= y1_nxt;
    off1_r   <= off1_nxt;
    secs1_r  <= secs1_nxt;
    fok1_r   <= fok1_nxt;
    year1_r  <= civ_i.year;
    month1_r <= civ_i.month;
    day1_r   <= civ_i.day;
  end

  // y/100 as (y/4)/25, y/400 as (y/100)/4
  jdc_cdiv #(.NW(13), .D(25), .QW(8), .RW(5)) u_div_cent (
    .clk   (clk),
    .num_i (y1_r[14:2]),
    .quo_o (q100),
    .rem_o ()
  );

  jdc_cdiv #(.NW(14), .D(25), .QW(10), .RW(5)) u_div_leap (
    .clk   (clk),
    .num_i (year1_r),
    .quo_o (),
    .rem_o (yr25)
  );

  always_comb begin
    carry2_c  = (secs1_r >= 17'(jdc_pkg::SECS_PER_DAY));
    secn2_nxt = carry2_c ? secs1_r - 17'(jdc_pkg::SECS_PER_DAY) : secs1_r;
    base2_nxt = 23'(y1_r) * 23'(jdc_pkg::DAYS_PER_YEAR) + 23'(y1_r[14:2])
              + 23'(off1_r) + 23'(day1_r) + 23'(carry2_c)
              - 23'(jdc_pkg::JD_OFS_FWD);
  end

  always_ff @(posedge clk) begin
    base2_r  <= base2_nxt;
    secn2_r  <= secn2_nxt;
    month2_r <= month1_r;
    day2_r   <= day1_r;
    fok2_r   <= fok1_r;
    ylo2_r   <= year1_r[3:0];
    base3_r  <= base2_r;
    secn3_r  <= secn2_r;
    month3_r <= month2_r;
    day3_r   <= day2_r;
    fok3_r   <= fok2_r;
    ylo3_r   <= ylo2_r;
  end

  always_comb begin
    leap4_c    = (ylo3_r[1:0] == 2'd0) && ((yr25 != 5'd0) || (ylo3_r[3:2] == 2'd0));
    jdn4_nxt   = base3_r - 23'(q100) + 23'(q100[7:2]);
    valid4_nxt = fok3_r && (day3_r <= jdc_pkg::mon_len(month3_r, leap4_c));
  end

  always_ff @(posedge clk) begin
    jdn4_r   <= jdn4_nxt;
    valid4_r <= valid4_nxt;
    secn4_r  <= secn3_r;
    jdn5_r   <= jdn4_r;
    valid5_r <= valid4_r;
    secn5_r  <= secn4_r;
    jdn6_r   <= jdn5_r;
    valid6_r <= valid5_r;
    secn6_r  <= secn5_r;
  end

  jdc_cdiv #(.NW(23), .D(7), .QW(20), .RW(3)) u_div_week (
    .clk   (clk),
    .num_i (jdn4_r),
    .quo_o (),
    .rem_o (wd6)
  );

  always_comb begin
    res_o.day_number     = jdn6_r;
    res_o.seconds_of_day = secn6_r;
    res_o.weekday        = wd6;
    res_o.date_valid     = valid6_r;
  end

endmodule

>>> sv/jdc_rev.sv
// Day number and seconds of day to civil date and time, six stages.
module jdc_rev (
  input  logic              clk,
  input  logic [22:0]       day_number_i,
  input  logic [16:0]       sod_i,
  output jdc_pkg::rev_res_t res_o
);

  logic        carry_c;
  logic [16:0] secn_c;
  logic [23:0] a_c;
  logic [25:0] num_quad;

  logic [7:0]  b2;
  logic [17:0] r1;
  logic [4:0]  h2;
  logic [11:0] rh2;
  logic [17:0] num_cyc;
  logic [6:0]  d4;
  logic [10:0] r2;
  logic [5:0]  mi4, s4;

  logic [7:0]  b3_r, b4_r, b5_r;
  logic [4:0]  h3_r, h4_r, h5_r, h6_r;
  logic [6:0]  d5_r;
  logic [5:0]  mi5_r, s5_r, mi6_r, s6_r;

  logic [8:0]  e5_nxt, e5_r;
  logic [3:0]  m5_nxt, m5_r;

  logic        ten6_c;
  logic [8:0]  day6_c;
  logic [14:0] year6_nxt, year6_r;
  logic [3:0]  month6_nxt, month6_r;
  logic [4:0]  day6_nxt, day6_r;

  always_comb begin
    carry_c  = (sod_i >= 17'(jdc_pkg::SECS_PER_DAY));
    secn_c   = carry_c ? sod_i - 17'(jdc_pkg::SECS_PER_DAY) : sod_i;
    a_c      = 24'(day_number_i) + 24'(carry_c) + 24'(jdc_pkg::JD_OFS_REV);
    num_quad = {a_c, 2'b11};
    num_cyc  = {r1[17:2], 2'b11};
  end

  jdc_cdiv #(.NW(26), .D(jdc_pkg::DAYS_400Y), .QW(8), .RW(18)) u_div_quad (
    .clk   (clk),
    .num_i (num_quad),
    .quo_o (b2),
    .rem_o (r1)
  );

  jdc_cdiv #(.NW(17), .D(jdc_pkg::SECS_PER_HOUR), .QW(5), .RW(12)) u_div_hour (
    .clk   (clk),
    .num_i (secn_c),
    .quo_o (h2),
    .rem_o (rh2)
  );

  jdc_cdiv #(.NW(18), .D(jdc_pkg::DAYS_4Y), .QW(7), .RW(11)) u_div_cyc (
    .clk   (clk),
    .num_i (num_cyc),
    .quo_o (d4),
    .rem_o (r2)
  );

  jdc_cdiv #(.NW(12), .D(jdc_pkg::SECS_PER_MIN), .QW(6), .RW(6)) u_div_min (
    .clk   (clk),
    .num_i (rh2),
    .quo_o (mi4),
    .rem_o (s4)
  );

  // shifted month: count of month starts after March at or below the day of year
  always_comb begin
    e5_nxt = r2[10:2];
    m5_nxt = 4'd0;
    for (int k = 1; k < jdc_pkg::MONTHS_PER_YEAR; k++) begin
      m5_nxt = m5_nxt + 4'(e5_nxt >= jdc_pkg::mon_ofs(4'(k)));
    end
  end

  always_ff @(posedge clk) begin
    b3_r  <= b2;
    h3_r  <= h2;
    b4_r  <= b3_r;
    h4_r  <= h3_r;
    b5_r  <= b4_r;
    h5_r  <= h4_r;
    d5_r  <= d4;
    mi5_r <= mi4;
    s5_r  <= s4;
    e5_r  <= e5_nxt;
    m5_r  <= m5_nxt;
  end

  always_comb begin
    ten6_c     = (m5_r >= 4'd10);
    month6_nxt = m5_r + 4'd3 - (ten6_c ? 4'(jdc_pkg::MONTHS_PER_YEAR) : 4'd0);
    day6_c     = e5_r + 9'd1 - jdc_pkg::mon_ofs(m5_r);
    day6_nxt   = day6_c[4:0];
    year6_nxt  = 15'(b5_r) * 15'(100) + 15'(d5_r) + 15'(ten6_c) - 15'(jdc_pkg::Y_OFS);
  end

  always_ff @(posedge clk) begin
    year6_r  <= year6_nxt;
    month6_r <= month6_nxt;
    day6_r   <= day6_nxt;
    h6_r     <= h5_r;
    mi6_r    <= mi5_r;
    s6_r     <= s5_r;
  end

  always_comb begin
    res_o.year   = year6_r;
    res_o.month  = month6_r;
    res_o.day    = day6_r;
    res_o.hour   = h6_r;
    res_o.minute = mi6_r;
    res_o.second = s6_r;
  end

endmodule

>>> sv/julian_day_conversion_core.sv
// Gregorian date and time <-> Julian day number converter, top level.
// Each taken start yields one result word, strobed on out_valid after the conversion pipeline and output register.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Reset clears the valid pipeline and out_valid; data registers are not reset.
module julian_day_conversion_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [13:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  input  logic [4:0]  in_hour_in,
  input  logic [5:0]  in_minute_in,
  input  logic [5:0]  in_second_in,
  input  logic [22:0] in_day_number_in,
  input  logic [16:0] in_seconds_of_day_in,
  output logic        out_valid,
  output logic [22:0] out_day_number_out,
  output logic [16:0] out_seconds_of_day_out,
  output logic [2:0]  out_weekday,
  output logic        out_date_valid,
  output logic signed [14:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out
);

  localparam int LAT = jdc_pkg::LAT;

  logic              accept;
  jdc_pkg::civil_t   civ;
  jdc_pkg::fwd_res_t fwd_res;
  jdc_pkg::rev_res_t rev_res;

  logic [LAT-1:0]    vld_nxt, vld_r;
  logic [LAT-1:0]    cmd_nxt, cmd_r;
  logic              out_valid_r, out_cmd_r;
  jdc_pkg::fwd_res_t out_fwd_nxt, out_fwd_r;
  jdc_pkg::rev_res_t out_rev_nxt, out_rev_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    civ.year   = in_year_in;
    civ.month  = in_month_in;
    civ.day    = in_day_in;
    civ.hour   = in_hour_in;
    civ.minute = in_minute_in;
    civ.second = in_second_in;
  end

  jdc_fwd u_fwd (
    .clk   (clk),
    .civ_i (civ),
    .res_o (fwd_res)
  );

  jdc_rev u_rev (
    .clk          (clk),
    .day_number_i (in_day_number_in),
    .sod_i        (in_seconds_of_day_in),
    .res_o        (rev_res)
  );

  // valid and command travel beside the data stages
  always_comb begin
    vld_nxt     = {vld_r[LAT-2:0], accept};
    cmd_nxt     = {cmd_r[LAT-2:0], in_command};
    out_fwd_nxt = (cmd_r[LAT-1] == jdc_pkg::CMD_TO_DATE) ? '0 : fwd_res;
    out_rev_nxt = (cmd_r[LAT-1] == jdc_pkg::CMD_TO_DAY) ? '0 : rev_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    out_cmd_r <= cmd_r[LAT-1];
    out_fwd_r <= out_fwd_nxt;
    out_rev_r <= out_rev_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_day_number_out     = out_fwd_r.day_number;
  assign out_seconds_of_day_out = out_fwd_r.seconds_of_day;
  assign out_weekday            = out_fwd_r.weekday;
  assign out_date_valid         = out_fwd_r.date_valid;
  assign out_year_out           = out_rev_r.year;
  assign out_month_out          = out_rev_r.month;
  assign out_day_out            = out_rev_r.day;
  assign out_hour_out           = out_rev_r.hour;
  assign out_minute_out         = out_rev_r.minute;
  assign out_second_out         = out_rev_r.second;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT + 1))
    else $error("result word without a matching start");

  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cmd_r == jdc_pkg::CMD_TO_DAY)) |->
      (out_weekday <= 3'd6) &&
      (out_seconds_of_day_out < 17'(jdc_pkg::SECS_PER_DAY)))
    else $error("weekday or seconds of day out of range");

  a_rev_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cmd_r == jdc_pkg::CMD_TO_DATE)) |->
      (out_month_out != 4'd0) && (out_month_out <= 4'd12) && (out_day_out != 5'd0) &&
      (out_hour_out <= 5'd23) && (out_minute_out <= 6'd59) && (out_second_out <= 6'd59))
    else $error("reverse conversion field out of range");

  a_rev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cmd_r == jdc_pkg::CMD_TO_DATE)) |->
      (out_day_number_out == 23'd0) && !out_date_valid)
    else $error("forward fields not cleared on reverse word");
`endif

endmodule

>>> test/julian_day_conversion_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the Julian day converter: directed and random words in both directions.
module julian_day_conversion_core_test;

  localparam int IDLE_LIMIT     = 2000;
  localparam int N_RANDOM       = 1250;
  localparam int MAX_DAY_NUMBER = 5373484;

  typedef struct {
    logic             cmd;
    jdc_pkg::civil_t  civ;
    logic [22:0]      day_number;
    logic [16:0]      seconds_of_day;
  } conv_req_t;

  typedef struct {
    logic              cmd;
    jdc_pkg::fwd_res_t fwd;
    jdc_pkg::rev_res_t rev;
  } conv_word_t;

  logic        clk                  = 1'b0;
  logic        rst_n                = 1'b0;
  logic        start                = 1'b0;
  logic        in_command           = 1'b0;
  logic [13:0] in_year_in           = '0;
  logic [3:0]  in_month_in          = '0;
  logic [4:0]  in_day_in            = '0;
  logic [4:0]  in_hour_in           = '0;
  logic [5:0]  in_minute_in         = '0;
  logic [5:0]  in_second_in         = '0;
  logic [22:0] in_day_number_in     = '0;
  logic [16:0] in_seconds_of_day_in = '0;

  logic        busy;
  logic        out_valid;
  logic [22:0] out_day_number_out;
  logic [16:0] out_seconds_of_day_out;
  logic [2:0]  out_weekday;
  logic        out_date_valid;
  logic signed [14:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [4:0]  out_hour_out;
  logic [5:0]  out_minute_out;
  logic [5:0]  out_second_out;

  conv_req_t  pending_q[$];
  conv_word_t expected_q[$];
  conv_req_t  drv_req;
  conv_word_t mon_word;
  int gap_left      = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;
  int errors        = 0;
  int n_to_day      = 0;
  int n_to_date     = 0;
  int n_valid_dates = 0;

  julian_day_conversion_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_year_in            (in_year_in),
    .in_month_in           (in_month_in),
    .in_day_in             (in_day_in),
    .in_hour_in            (in_hour_in),
    .in_minute_in          (in_minute_in),
    .in_second_in          (in_second_in),
    .in_day_number_in      (in_day_number_in),
    .in_seconds_of_day_in  (in_seconds_of_day_in),
    .out_valid             (out_valid),
    .out_day_number_out    (out_day_number_out),
    .out_seconds_of_day_out(out_seconds_of_day_out),
    .out_weekday           (out_weekday),
    .out_date_valid        (out_date_valid),
    .out_year_out          (out_year_out),
    .out_month_out         (out_month_out),
    .out_day_out           (out_day_out),
    .out_hour_out          (out_hour_out),
    .out_minute_out        (out_minute_out),
    .out_second_out        (out_second_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit leap_year(int yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int days_in_month(int mo, int yr);
    case (mo)
      4, 6, 9, 11: return 30;
      2:           return leap_year(yr) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic jdc_pkg::fwd_res_t calc_day_number(jdc_pkg::civil_t c);
    longint yr, mo, dy, hr, mi, sc, a, y, m, jd, secs;
    jdc_pkg::fwd_res_t r;
    yr = longint'(c.year);
    mo = longint'(c.month);
    dy = longint'(c.day);
    hr = longint'(c.hour);
    mi = longint'(c.minute);
    sc = longint'(c.second);
    a = (14 - mo) / jdc_pkg::MONTHS_PER_YEAR;
    y = yr + jdc_pkg::Y_OFS - a;
    m = mo + jdc_pkg::MONTHS_PER_YEAR * a - 3;
    jd = dy + (153 * m + 2) / 5 + jdc_pkg::DAYS_PER_YEAR * y + y / 4 - y / 100 + y / 400
       - jdc_pkg::JD_OFS_FWD;
    secs = hr * jdc_pkg::SECS_PER_HOUR + mi * jdc_pkg::SECS_PER_MIN + sc;
    jd = jd + secs / jdc_pkg::SECS_PER_DAY;
    secs = secs % jdc_pkg::SECS_PER_DAY;
    r.day_number     = 23'(jd);
    r.seconds_of_day = 17'(secs);
    r.weekday        = 3'(jd % 7);
    r.date_valid     = (mo >= 1) && (mo <= 12) && (dy >= 1) &&
                       (dy <= days_in_month(int'(mo), int'(yr))) &&
                       (hr <= 23) && (mi <= 59) && (sc <= 59);
    return r;
  endfunction

  function automatic jdc_pkg::rev_res_t calc_civil_date(logic [22:0] day_number,
                                                        logic [16:0] sod);
    longint jd, secs, a, b, c, d, e, m, ten;
    jdc_pkg::rev_res_t r;
    jd = longint'(day_number);
    secs = longint'(sod);
    jd = jd + secs / jdc_pkg::SECS_PER_DAY;
    secs = secs % jdc_pkg::SECS_PER_DAY;
    a = jd + jdc_pkg::JD_OFS_REV;
    b = (4 * a + 3) / jdc_pkg::DAYS_400Y;
    c = a - (jdc_pkg::DAYS_400Y * b) / 4;
    d = (4 * c + 3) / jdc_pkg::DAYS_4Y;
    e = c - (jdc_pkg::DAYS_4Y * d) / 4;
    m = (5 * e + 2) / 153;
    ten = m / 10;
    r.year   = 15'(100 * b + d - jdc_pkg::Y_OFS + ten);
    r.month  = 4'(m + 3 - jdc_pkg::MONTHS_PER_YEAR * ten);
    r.day    = 5'(e - (153 * m + 2) / 5 + 1);
    r.hour   = 5'(secs / jdc_pkg::SECS_PER_HOUR);
    r.minute = 6'((secs % jdc_pkg::SECS_PER_HOUR) / jdc_pkg::SECS_PER_MIN);
    r.second = 6'(secs % jdc_pkg::SECS_PER_MIN);
    return r;
  endfunction

  function automatic conv_word_t convert_word(conv_req_t q);
    conv_word_t w;
    w.cmd = q.cmd;
    w.fwd = '0;
    w.rev = '0;
    if (q.cmd == jdc_pkg::CMD_TO_DAY) begin
      w.fwd = calc_day_number(q.civ);
    end else begin
      w.rev = calc_civil_date(q.day_number, q.seconds_of_day);
    end
    return w;
  endfunction

  function automatic jdc_pkg::civil_t mk_civil(int yr, int mo, int dy, int hr, int mi, int sc);
    jdc_pkg::civil_t c;
    c.year   = 14'(yr);
    c.month  = 4'(mo);
    c.day    = 5'(dy);
    c.hour   = 5'(hr);
    c.minute = 6'(mi);
    c.second = 6'(sc);
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  task automatic push_to_day(input jdc_pkg::civil_t c);
    conv_req_t q;
    q.cmd            = jdc_pkg::CMD_TO_DAY;
    q.civ            = c;
    q.day_number     = 23'($urandom);
    q.seconds_of_day = 17'($urandom);
    pending_q.push_back(q);
  endtask

  task automatic push_to_date(input logic [22:0] jd, input logic [16:0] sod);
    conv_req_t q;
    q.cmd            = jdc_pkg::CMD_TO_DATE;
    q.civ            = 40'({$urandom, $urandom});
    q.day_number     = jd;
    q.seconds_of_day = sod;
    pending_q.push_back(q);
  endtask

  task automatic check_field(input string name, input logic [22:0] exp_v,
                             input logic [22:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (start && !busy) begin
      expected_q.push_back(convert_word(drv_req));
      if (burst_left > 0) begin
        burst_left--;
        gap_left = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        burst_left = $urandom_range(20, 80);
        gap_left = 0;
      end else begin
        gap_left = pick_gap();
      end
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_q.size() > 0) begin
      drv_req = pending_q.pop_front();
      in_command           <= drv_req.cmd;
      in_year_in           <= drv_req.civ.year;
      in_month_in          <= drv_req.civ.month;
      in_day_in            <= drv_req.civ.day;
      in_hour_in           <= drv_req.civ.hour;
      in_minute_in         <= drv_req.civ.minute;
      in_second_in         <= drv_req.civ.second;
      in_day_number_in     <= drv_req.day_number;
      in_seconds_of_day_in <= drv_req.seconds_of_day;
      start                <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if ((start && !busy) || (rst_n && out_valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected", $time);
      end else begin
        mon_word = expected_q.pop_front();
        check_field("day_number", mon_word.fwd.day_number, out_day_number_out);
        check_field("seconds_of_day", 23'(mon_word.fwd.seconds_of_day),
                    23'(out_seconds_of_day_out));
        check_field("weekday", 23'(mon_word.fwd.weekday), 23'(out_weekday));
        check_field("date_valid", 23'(mon_word.fwd.date_valid), 23'(out_date_valid));
        check_field("year", 23'(mon_word.rev.year), {8'd0, out_year_out});
        check_field("month", 23'(mon_word.rev.month), 23'(out_month_out));
        check_field("day", 23'(mon_word.rev.day), 23'(out_day_out));
        check_field("hour", 23'(mon_word.rev.hour), 23'(out_hour_out));
        check_field("minute", 23'(mon_word.rev.minute), 23'(out_minute_out));
        check_field("second", 23'(mon_word.rev.second), 23'(out_second_out));
        if (mon_word.cmd == jdc_pkg::CMD_TO_DAY) begin
          n_to_day++;
          if (mon_word.fwd.date_valid) n_valid_dates++;
        end else begin
          n_to_date++;
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("** julian_day_conversion_core: FAILED **");
    $finish;
  end

  initial begin
    int kind, yr, mo, dy;

    push_to_day(mk_civil(2000, 1, 1, 12, 0, 0));
    push_to_day(mk_civil(2000, 2, 29, 0, 0, 0));
    push_to_day(mk_civil(1900, 2, 29, 0, 0, 0));
    push_to_day(mk_civil(2023, 2, 29, 6, 30, 0));
    push_to_day(mk_civil(2023, 2, 28, 6, 30, 0));
    push_to_day(mk_civil(2024, 2, 29, 23, 59, 59));
    push_to_day(mk_civil(0, 2, 29, 0, 0, 0));
    push_to_day(mk_civil(0, 1, 1, 0, 0, 0));
    push_to_day(mk_civil(9999, 12, 31, 23, 59, 59));
    push_to_day(mk_civil(16383, 15, 31, 31, 63, 63));
    push_to_day(mk_civil(0, 0, 0, 0, 0, 0));
    push_to_day(mk_civil(2021, 13, 1, 1, 1, 1));
    push_to_day(mk_civil(2021, 4, 31, 10, 0, 0));
    push_to_day(mk_civil(2021, 4, 30, 10, 0, 0));
    push_to_day(mk_civil(2021, 6, 15, 24, 0, 0));
    push_to_day(mk_civil(2021, 6, 15, 0, 60, 0));
    push_to_day(mk_civil(2021, 6, 15, 0, 0, 60));
    push_to_date(23'd0, 17'd0);
    push_to_date(23'd2451545, 17'd43200);
    push_to_date(23'(MAX_DAY_NUMBER), 17'd86399);
    push_to_date(23'h7FFFFF, 17'h1FFFF);
    push_to_date(23'd2459580, 17'd86400);
    push_to_date(23'd2299160, 17'd0);
    push_to_date(23'd1721120, 17'd3661);

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        yr = $urandom_range(0, 9999);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, days_in_month(mo, yr));
        push_to_day(mk_civil(yr, mo, dy, $urandom_range(0, 23), $urandom_range(0, 59),
                             $urandom_range(0, 59)));
      end else if (kind < 55) begin
        // month ends and the day past them, often in century years
        yr = $urandom_range(0, 1) ? $urandom_range(0, 99) * 100 : $urandom_range(0, 9999);
        mo = $urandom_range(1, 12);
        dy = days_in_month(mo, yr) + $urandom_range(0, 1);
        push_to_day(mk_civil(yr, mo, dy, $urandom_range(0, 23), $urandom_range(0, 59),
                             $urandom_range(0, 59)));
      end else if (kind < 65) begin
        push_to_day(40'({$urandom, $urandom}));
      end else if (kind < 93) begin
        push_to_date(23'($urandom_range(0, MAX_DAY_NUMBER)), 17'($urandom_range(0, 86399)));
      end else begin
        push_to_date(23'($urandom), 17'($urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    repeat (4 * jdc_pkg::LAT) @(posedge clk);

    $display("Checked %0d date-to-day words (%0d valid dates) and %0d day-to-date words,",
             n_to_day, n_valid_dates, n_to_date);
    $display("covering leap rules, invalid fields, day carries and full-width day numbers.");
    if (errors == 0) begin
      $display("** julian_day_conversion_core: PASSED **");
    end else begin
      $display("** julian_day_conversion_core: FAILED **");
    end
    $finish;
  end

endmodule
